FILE: hdl/ftmq_pkg.sv
// ----------------------------------------------------------------------------
// ftmq_pkg
// Shared types and constants of the frame timestamp match queue.
// ----------------------------------------------------------------------------
package ftmq_pkg;

    localparam int QUEUE_DEPTH_DEF = 20;
    localparam int SEQ_W           = 32;
    localparam int STAMP_W         = 64;
    localparam int COUNT_OUT_W     = 5;

    localparam logic [SEQ_W-1:0]   SEQ_TAKE_OLDEST    = '0;
    localparam logic [STAMP_W-1:0] PREDICT_BACKOFF_NS = 64'd1000;
    localparam logic [STAMP_W-1:0] INTERVAL_UNKNOWN   = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_PUSHED    = 2'd0,
        ST_DUP       = 2'd1,
        ST_POPPED    = 2'd2,
        ST_PREDICTED = 2'd3
    } status_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [SEQ_W-1:0]   seq;
        logic [STAMP_W-1:0] stamp;
    } tok_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic pop;
        logic commit_pop;
        logic commit_push;
        logic p_full;
        logic h_full;
    } cmd_t;

endpackage

FILE: hdl/ftmq_cell.sv
// ----------------------------------------------------------------------------
// ftmq_cell
// One slot of the pending queue and of the stamp history, with its search step.
// ----------------------------------------------------------------------------
module ftmq_cell #(
    parameter int IDX     = 0,
    parameter int COUNT_W = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ftmq_pkg::cmd_t               cmd,
    input  logic [COUNT_W-1:0]           pcount,
    input  logic [COUNT_W-1:0]           hcount,
    input  logic [ftmq_pkg::SEQ_W-1:0]   req_seq,
    input  logic [ftmq_pkg::STAMP_W-1:0] req_stamp,
    input  ftmq_pkg::tok_t               tok_i,
    output ftmq_pkg::tok_t               tok_o,
    input  logic [ftmq_pkg::SEQ_W-1:0]   nb_seq_i,
    input  logic [ftmq_pkg::STAMP_W-1:0] nb_pstamp_i,
    input  logic [ftmq_pkg::STAMP_W-1:0] nb_hstamp_i,
    output logic [ftmq_pkg::SEQ_W-1:0]   seq_o,
    output logic [ftmq_pkg::STAMP_W-1:0] pstamp_o,
    output logic [ftmq_pkg::STAMP_W-1:0] hstamp_o
);

    localparam logic [COUNT_W-1:0] MY_IDX = COUNT_W'(IDX);

    logic [ftmq_pkg::SEQ_W-1:0]   p_seq_reg,    p_seq_next;
    logic [ftmq_pkg::STAMP_W-1:0] p_stamp_reg,  p_stamp_next;
    logic [ftmq_pkg::STAMP_W-1:0] h_stamp_reg,  h_stamp_next;
    logic                         shift_reg,    shift_next;
    ftmq_pkg::tok_t               tok_reg,      tok_next;

    logic p_in;
    logic h_in;
    logic hit;

    always_comb begin
        p_in = MY_IDX < pcount;
        h_in = MY_IDX < hcount;
        if (cmd.pop) begin
            hit = p_in && (req_seq == ftmq_pkg::SEQ_TAKE_OLDEST || p_seq_reg == req_seq);
        end else begin
            hit = (p_in && p_seq_reg == req_seq && p_stamp_reg == req_stamp) ||
                  (h_in && h_stamp_reg == req_stamp);
        end

        tok_next       = tok_i;
        tok_next.valid = tok_i.valid;
        if (tok_i.valid && hit && !tok_i.hit) begin
            tok_next.hit   = 1'b1;
            tok_next.seq   = p_seq_reg;
            tok_next.stamp = p_stamp_reg;
        end

        shift_next = shift_reg;
        if (cmd.clear) begin
            shift_next = 1'b0;
        end else if (tok_i.valid && (tok_i.hit || hit)) begin
            shift_next = 1'b1;
        end

        p_seq_next   = p_seq_reg;
        p_stamp_next = p_stamp_reg;
        h_stamp_next = h_stamp_reg;
        if (cmd.commit_pop && shift_reg) begin
            p_seq_next   = nb_seq_i;
            p_stamp_next = nb_pstamp_i;
        end
        if (cmd.commit_push) begin
            if (cmd.p_full) begin
                p_seq_next   = nb_seq_i;
                p_stamp_next = nb_pstamp_i;
            end else if (MY_IDX == pcount) begin
                p_seq_next   = req_seq;
                p_stamp_next = req_stamp;
            end
            if (cmd.h_full) begin
                h_stamp_next = nb_hstamp_i;
            end else if (MY_IDX == hcount) begin
                h_stamp_next = req_stamp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            shift_reg <= shift_next;
            tok_reg   <= tok_next;
        end
        p_seq_reg   <= p_seq_next;
        p_stamp_reg <= p_stamp_next;
        h_stamp_reg <= h_stamp_next;
    end

    assign tok_o    = tok_reg;
    assign seq_o    = p_seq_reg;
    assign pstamp_o = p_stamp_reg;
    assign hstamp_o = h_stamp_reg;

endmodule

FILE: hdl/frame_timestamp_match_queue.sv
// ----------------------------------------------------------------------------
// frame_timestamp_match_queue
// Bounded queue of frame capture stamps with duplicate filter and prediction.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction is a push (tuser 0) of a sequence number
// and capture stamp, or a pop (tuser 1) of a sequence number, 0 = oldest.
// Result channel m_*: exactly one transaction per input, carrying the status
// in tuser and popped/predicted stamp, sequence and pending count in tdata.
// Each item walks a search token through a row of QUEUE_DEPTH cells, one cell
// per cycle, then commits once the result register is free. The next item can
// be accepted as soon as the result is registered, but not before: the block
// takes no new item while one is still being searched or committed.
// The result register frees the input side: a new item is accepted and
// searched while the previous result waits; the commit waits only if that
// result has still not been taken.
// Reset empties the queue and history, clears the latest stamp and marks the
// minimum interval as unknown; no clearing pass is needed.
// ----------------------------------------------------------------------------
module frame_timestamp_match_queue #(
    parameter int QUEUE_DEPTH = ftmq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // seq_num[31:0], stamp_ns[95:32]
    input  logic [0:0]   s_tuser,   // req_type[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // out_seq[31:0], frame_stamp[95:32],
                                    // queue_count[100:96], zero[103:101]
    output logic [1:0]   m_tuser    // status[1:0]
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(QUEUE_DEPTH);
    localparam int SW = ftmq_pkg::SEQ_W;
    localparam int TW = ftmq_pkg::STAMP_W;
    localparam int OW = ftmq_pkg::COUNT_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                 state_reg,    state_next;
    logic                   launch_reg,   launch_next;
    logic [COUNT_W-1:0]     pcount_reg,   pcount_next;
    logic [COUNT_W-1:0]     hcount_reg,   hcount_next;
    logic [TW-1:0]          latest_reg,   latest_next;
    logic [TW-1:0]          min_reg,      min_next;
    logic                   req_pop_reg,  req_pop_next;
    logic [SW-1:0]          req_seq_reg,  req_seq_next;
    logic [TW-1:0]          req_stamp_reg, req_stamp_next;
    logic [TW-1:0]          interval_reg, interval_next;
    logic [TW-1:0]          pred_reg,     pred_next;
    logic                   res_hit_reg,  res_hit_next;
    logic [SW-1:0]          res_seq_reg,  res_seq_next;
    logic [TW-1:0]          res_stamp_reg, res_stamp_next;
    logic                   m_valid_reg,  m_valid_next;
    ftmq_pkg::status_t      status_reg,   status_next;
    logic [SW-1:0]          oseq_reg,     oseq_next;
    logic [TW-1:0]          ostamp_reg,   ostamp_next;
    logic [OW-1:0]          ocount_reg,   ocount_next;

    ftmq_pkg::cmd_t         cmd;
    ftmq_pkg::tok_t         tok_head;
    ftmq_pkg::tok_t         tok [QUEUE_DEPTH+1];
    logic [SW-1:0]          nb_seq    [QUEUE_DEPTH+1];
    logic [TW-1:0]          nb_pstamp [QUEUE_DEPTH+1];
    logic [TW-1:0]          nb_hstamp [QUEUE_DEPTH+1];

    logic accept;
    logic out_free;
    logic commit;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign commit   = (state_reg == S_DONE) && out_free;

    always_comb begin
        tok_head       = '0;
        tok_head.valid = launch_reg;

        cmd.clear       = accept;
        cmd.pop         = req_pop_reg;
        cmd.commit_pop  = commit && req_pop_reg && res_hit_reg;
        cmd.commit_push = commit && !req_pop_reg && !res_hit_reg;
        cmd.p_full      = pcount_reg >= DEPTH_C;
        cmd.h_full      = hcount_reg >= DEPTH_C;
    end

    assign tok[0]                 = tok_head;
    assign nb_seq[QUEUE_DEPTH]    = req_seq_reg;
    assign nb_pstamp[QUEUE_DEPTH] = req_stamp_reg;
    assign nb_hstamp[QUEUE_DEPTH] = req_stamp_reg;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        ftmq_cell #(
            .IDX     (i),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .pcount      (pcount_reg),
            .hcount      (hcount_reg),
            .req_seq     (req_seq_reg),
            .req_stamp   (req_stamp_reg),
            .tok_i       (tok[i]),
            .tok_o       (tok[i+1]),
            .nb_seq_i    (nb_seq[i+1]),
            .nb_pstamp_i (nb_pstamp[i+1]),
            .nb_hstamp_i (nb_hstamp[i+1]),
            .seq_o       (nb_seq[i]),
            .pstamp_o    (nb_pstamp[i]),
            .hstamp_o    (nb_hstamp[i])
        );
    end

    always_comb begin
        state_next     = state_reg;
        launch_next    = accept;
        pcount_next    = pcount_reg;
        hcount_next    = hcount_reg;
        latest_next    = latest_reg;
        min_next       = min_reg;
        req_pop_next   = req_pop_reg;
        req_seq_next   = req_seq_reg;
        req_stamp_next = req_stamp_reg;
        interval_next  = req_stamp_reg - latest_reg;
        pred_next      = (min_reg == ftmq_pkg::INTERVAL_UNKNOWN) ? latest_reg :
                         latest_reg + min_reg - ftmq_pkg::PREDICT_BACKOFF_NS;
        res_hit_next   = res_hit_reg;
        res_seq_next   = res_seq_reg;
        res_stamp_next = res_stamp_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        status_next    = status_reg;
        oseq_next      = oseq_reg;
        ostamp_next    = ostamp_reg;
        ocount_next    = ocount_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_pop_next   = (s_tuser[0] == ftmq_pkg::REQ_POP);
                    req_seq_next   = s_tdata[31:0];
                    req_stamp_next = s_tdata[95:32];
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok[QUEUE_DEPTH].valid) begin
                    res_hit_next   = tok[QUEUE_DEPTH].hit;
                    res_seq_next   = tok[QUEUE_DEPTH].seq;
                    res_stamp_next = tok[QUEUE_DEPTH].stamp;
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    oseq_next   = '0;
                    ostamp_next = '0;
                    if (req_pop_reg) begin
                        if (res_hit_reg) begin
                            status_next = ftmq_pkg::ST_POPPED;
                            oseq_next   = res_seq_reg;
                            ostamp_next = res_stamp_reg;
                            pcount_next = pcount_reg - COUNT_W'(1);
                        end else begin
                            status_next = ftmq_pkg::ST_PREDICTED;
                            ostamp_next = pred_reg;
                        end
                    end else if (res_hit_reg) begin
                        status_next = ftmq_pkg::ST_DUP;
                    end else begin
                        status_next = ftmq_pkg::ST_PUSHED;
                        if (!cmd.p_full) begin
                            pcount_next = pcount_reg + COUNT_W'(1);
                        end
                        if (!cmd.h_full) begin
                            hcount_next = hcount_reg + COUNT_W'(1);
                        end
                        if ($signed(interval_reg) < $signed(min_reg)) begin
                            min_next = interval_reg;
                        end
                        latest_next = req_stamp_reg;
                    end
                    ocount_next  = OW'(pcount_next);
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            launch_reg  <= 1'b0;
            pcount_reg  <= '0;
            hcount_reg  <= '0;
            latest_reg  <= '0;
            min_reg     <= ftmq_pkg::INTERVAL_UNKNOWN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            pcount_reg  <= pcount_next;
            hcount_reg  <= hcount_next;
            latest_reg  <= latest_next;
            min_reg     <= min_next;
            m_valid_reg <= m_valid_next;
        end
        req_pop_reg   <= req_pop_next;
        req_seq_reg   <= req_seq_next;
        req_stamp_reg <= req_stamp_next;
        interval_reg  <= interval_next;
        pred_reg      <= pred_next;
        res_hit_reg   <= res_hit_next;
        res_seq_reg   <= res_seq_next;
        res_stamp_reg <= res_stamp_next;
        status_reg    <= status_next;
        oseq_reg      <= oseq_next;
        ostamp_reg    <= ostamp_next;
        ocount_reg    <= ocount_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, ocount_reg, ostamp_reg, oseq_reg};

endmodule

FILE: hdl/ftmq_checker.sv
// ----------------------------------------------------------------------------
// ftmq_checker
// Port-level checks of the frame timestamp match queue, bound to the top level.
// ----------------------------------------------------------------------------
module ftmq_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [95:0]  s_tdata,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [1:0]   m_tuser
);

    logic [96:0] in_sample;
    assign in_sample = {s_tuser, s_tdata};

    a_reset_clears_out : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_one_at_a_time : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while an item is in flight");

    a_in_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(in_sample))
        else $error("waiting input transaction changed");

    a_push_fields_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ftmq_pkg::ST_PUSHED || m_tuser == ftmq_pkg::ST_DUP)
        |-> m_tdata[95:0] == '0 && m_tdata[103:101] == '0)
        else $error("push result carries nonzero sequence or stamp");

    a_out_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind frame_timestamp_match_queue ftmq_checker u_ftmq_checker (.*);
